>>> src/ocs_pkg.sv
package ocs_pkg;

    localparam int BYTE_W    = 8;
    localparam int SUM_W     = 32;
    localparam int HALF_W    = 16;
    localparam int S_TDATA_W = 40;   // data_byte + start_value
    localparam int M_TDATA_W = 48;   // raw_sum + checksum

    typedef struct packed {
        logic [SUM_W-1:0]  start_value;
        logic              last_byte;
        logic              first_byte;
        logic [BYTE_W-1:0] data_byte;
    } ocs_word_t;

    // Single fold (no end-around carry), complement, keep low half.
    function automatic logic [HALF_W-1:0] fold_complement(input logic [SUM_W-1:0] sum);
        logic [HALF_W-1:0] folded;
        folded = sum[SUM_W-1:HALF_W] + sum[HALF_W-1:0];
        return ~folded;
    endfunction

endpackage

>>> src/ocs_in_stage.sv
module ocs_in_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ocs_pkg::S_TDATA_W-1:0]    s_tdata,  // data_byte[7:0], start_value[39:8]
    input  logic                             s_tlast,  // last_byte
    input  logic                             s_tuser,  // first_byte
    input  logic                             take,
    output logic                             word_valid,
    output ocs_pkg::ocs_word_t               word
);
    import ocs_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    ocs_word_t word_reg;

    // Refill in the same cycle the held word moves on.
    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            word_reg.data_byte   <= s_tdata[BYTE_W-1:0];
            word_reg.start_value <= s_tdata[S_TDATA_W-1:BYTE_W];
            word_reg.first_byte  <= s_tuser;
            word_reg.last_byte   <= s_tlast;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

>>> src/ocs_accum.sv
module ocs_accum (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             word_valid,
    input  ocs_pkg::ocs_word_t               word,
    output logic                             take,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ocs_pkg::M_TDATA_W-1:0]    m_tdata   // raw_sum[31:0], checksum[47:32]
);
    import ocs_pkg::*;

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic              odd_reg;
    logic              odd_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [SUM_W-1:0]  raw_reg;
    logic [HALF_W-1:0] csum_reg;
    logic [SUM_W-1:0]  base;
    logic [SUM_W-1:0]  addend;
    logic              odd_now;
    logic              out_free;

    assign out_free = !out_valid_reg || m_tready;
    // A last word waits until the result register can take it.
    assign take     = word_valid && (!word.last_byte || out_free);

    always_comb begin
        base    = word.first_byte ? word.start_value : sum_reg;
        odd_now = word.first_byte ? 1'b0 : odd_reg;
        addend  = odd_now ? {{(SUM_W-2*BYTE_W){1'b0}}, word.data_byte, {BYTE_W{1'b0}}}
                          : {{(SUM_W-BYTE_W){1'b0}}, word.data_byte};
        sum_next = sum_reg;
        odd_next = odd_reg;
        if (take) begin
            sum_next = base + addend;
            odd_next = word.last_byte ? 1'b0 : !odd_now;
        end
        out_valid_next = out_valid_reg && !m_tready;
        if (take && word.last_byte) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            odd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            odd_reg       <= odd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && word.last_byte) begin
            raw_reg  <= sum_next;
            csum_reg <= fold_complement(sum_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {csum_reg, raw_reg};

endmodule

>>> src/ones_complement_checksum16.sv
// Channel | Dir | tdata                                   | tlast     | tuser
// s_      | in  | [7:0] data_byte, [39:8] start_value     | last_byte | first_byte
// m_      | out | [31:0] raw_sum, [47:32] checksum        | -         | -
//
// One word per cycle sustained unless a last word waits on a stalled result; after its last word
// is accepted, that word sits in the input register, then the result register loads.
// The 32-bit accumulator add plus the single 16-bit fold sit between the two.
// Reset (aresetn low, synchronous) clears the sum, the offset parity and both valids.
// A stalled result blocks only the next last word; other words keep flowing.
module ones_complement_checksum16 (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ocs_pkg::S_TDATA_W-1:0]    s_tdata,  // data_byte[7:0], start_value[39:8]
    input  logic                             s_tlast,  // last_byte
    input  logic                             s_tuser,  // first_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ocs_pkg::M_TDATA_W-1:0]    m_tdata   // raw_sum[31:0], checksum[47:32]
);
    import ocs_pkg::*;

    logic      word_valid;
    ocs_word_t word;
    logic      take;

    // Input register: holds one word ahead of the accumulator.
    ocs_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    // Accumulator, fold and result register.
    ocs_accum u_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word_valid (word_valid),
        .word       (word),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

`ifndef SYNTHESIS
    // A new result only follows a last word leaving the input register.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(take && word.last_byte))
        else $error("result without a last word");

    // Checksum field always matches the raw sum beside it.
    a_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:SUM_W] == fold_complement(m_tdata[SUM_W-1:0])))
        else $error("checksum does not match raw sum");

    // A last word is held while the result register is stalled.
    a_last_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (word_valid && word.last_byte && m_tvalid && !m_tready) |=> word_valid)
        else $error("last word dropped under stall");
`endif

endmodule
